@@ sv/isd_pkg.sv @@
`default_nettype none
// Package for the +IPD stream deframer: widths, tag strings, byte codes, operation codes.
// No dependencies; used by ipd_stream_deframer_core.
package isd_pkg;

   // Length counter width
   localparam int LENGTH_BITS = 16;

   // Window lengths in bytes, and the width of their fill counters
   localparam int FILL_BITS = 3;
   localparam logic [FILL_BITS-1:0] TAG_LEN  = 3'd5;
   localparam logic [FILL_BITS-1:0] SEND_LEN = 3'd7;

   // Tags, first byte in the most significant position
   localparam logic [8*5-1:0] IPD_TAG  = "+IPD,";
   localparam logic [8*7-1:0] SEND_TAG = "SEND OK";

   // Byte codes of the length field
   localparam logic [7:0] CHAR_ZERO  = "0";
   localparam logic [7:0] CHAR_NINE  = "9";
   localparam logic [7:0] CHAR_COLON = ":";

   // Operation codes
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

endpackage
`default_nettype wire

@@ sv/ipd_stream_deframer_core.sv @@
`default_nettype none
// +IPD,<len>:<payload> deframer. One beat in, one result beat out.
// The result is registered and shows in the cycle after the beat is accepted.
// Throughput: one byte per cycle while results are taken; a result held by rsp_ready low stalls the input.
// The input stays ready while a result waits, as long as the result is taken in the same cycle.
// Reset (synchronous, active high) returns to scanning with empty windows and a clear send flag.
// Depends on isd_pkg.
module ipd_stream_deframer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_payload_valid,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_frame_last,
   output logic            rsp_header_error,
   output logic            rsp_send_ok_seen
);

   localparam int LB = isd_pkg::LENGTH_BITS;

   typedef enum logic [1:0] {
      MODE_SCAN    = 2'd0,
      MODE_DIGITS  = 2'd1,
      MODE_PAYLOAD = 2'd2
   } mode_type;

   // Parser state
   mode_type                        mode_ff, mode_in;
   logic [8*5-1:0]                  tag_win_ff, tag_win_in;
   logic [isd_pkg::FILL_BITS-1:0]   tag_fill_ff, tag_fill_in;
   logic [LB-1:0]                   bytes_left_ff, bytes_left_in;
   logic [8*7-1:0]                  send_win_ff, send_win_in;
   logic [isd_pkg::FILL_BITS-1:0]   send_fill_ff, send_fill_in;
   logic                            send_flag_ff, send_flag_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       pay_valid_ff, pay_valid_in;
   logic [7:0] pay_byte_ff, pay_byte_in;
   logic       last_ff, last_in;
   logic       herr_ff, herr_in;
   logic       sok_ff, sok_in;

   logic            accept;
   logic            clear_all;
   logic            is_digit;
   logic [LB+3:0]   len_ext;
   logic [LB+3:0]   len_times10;
   logic [LB-1:0]   bytes_dec;
   logic [8*5-1:0]  tag_shift;
   logic [8*7-1:0]  send_shift;

   // Input side takes a beat whenever the result slot is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Datapath pieces for the modes
   assign is_digit    = (req_rx_byte >= isd_pkg::CHAR_ZERO) &&
                        (req_rx_byte <= isd_pkg::CHAR_NINE);
   assign len_ext     = {4'b0000, bytes_left_ff};
   assign len_times10 = (len_ext << 3) + (len_ext << 1) +
                        {{LB{1'b0}}, req_rx_byte[3:0]};
   assign bytes_dec   = bytes_left_ff - {{(LB-1){1'b0}}, 1'b1};
   assign tag_shift   = {tag_win_ff[8*4-1:0], req_rx_byte};
   assign send_shift  = {send_win_ff[8*6-1:0], req_rx_byte};

   // Next state and next result
   always_comb begin
      mode_in       = mode_ff;
      tag_win_in    = tag_win_ff;
      tag_fill_in   = tag_fill_ff;
      bytes_left_in = bytes_left_ff;
      send_win_in   = send_win_ff;
      send_fill_in  = send_fill_ff;
      send_flag_in  = send_flag_ff;
      pay_valid_in  = 1'b0;
      pay_byte_in   = 8'h00;
      last_in       = 1'b0;
      herr_in       = 1'b0;
      clear_all     = 1'b0;

      if (req_operation == isd_pkg::OP_RESTART) begin
         clear_all = 1'b1;
      end else begin
         unique case (mode_ff)
            MODE_PAYLOAD: begin
               pay_valid_in  = 1'b1;
               pay_byte_in   = req_rx_byte;
               bytes_left_in = bytes_dec;
               if (bytes_dec == '0) begin
                  last_in     = 1'b1;
                  mode_in     = MODE_SCAN;
                  tag_fill_in = '0;
               end
            end
            MODE_DIGITS: begin
               if (is_digit) begin
                  // overflow past the counter width is a malformed header
                  if (len_times10[LB+3:LB] != 4'b0000) begin
                     clear_all = 1'b1;
                     herr_in   = 1'b1;
                  end else begin
                     bytes_left_in = len_times10[LB-1:0];
                  end
               end else if (req_rx_byte == isd_pkg::CHAR_COLON) begin
                  if (bytes_left_ff == '0) begin
                     mode_in     = MODE_SCAN;
                     tag_fill_in = '0;
                  end else begin
                     mode_in = MODE_PAYLOAD;
                  end
               end else begin
                  clear_all = 1'b1;
                  herr_in   = 1'b1;
               end
            end
            default: begin
               // scanning: both windows take the byte
               tag_win_in  = tag_shift;
               send_win_in = send_shift;
               if (tag_fill_ff < isd_pkg::TAG_LEN)
                  tag_fill_in = tag_fill_ff + 1'b1;
               if (send_fill_ff < isd_pkg::SEND_LEN)
                  send_fill_in = send_fill_ff + 1'b1;
               if ((tag_fill_ff >= isd_pkg::TAG_LEN - 1'b1) &&
                   (tag_shift == isd_pkg::IPD_TAG)) begin
                  mode_in       = MODE_DIGITS;
                  bytes_left_in = '0;
               end
               if ((send_fill_ff >= isd_pkg::SEND_LEN - 1'b1) &&
                   (send_shift == isd_pkg::SEND_TAG))
                  send_flag_in = 1'b1;
            end
         endcase
      end

      // restart or malformed header: everything back to reset values
      if (clear_all) begin
         mode_in       = MODE_SCAN;
         tag_win_in    = '0;
         tag_fill_in   = '0;
         bytes_left_in = '0;
         send_win_in   = '0;
         send_fill_in  = '0;
         send_flag_in  = 1'b0;
      end

      sok_in = send_flag_in;

      // result slot
      if (accept)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SCAN;
         tag_win_ff    <= '0;
         tag_fill_ff   <= '0;
         bytes_left_ff <= '0;
         send_win_ff   <= '0;
         send_fill_ff  <= '0;
         send_flag_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff       <= mode_in;
            tag_win_ff    <= tag_win_in;
            tag_fill_ff   <= tag_fill_in;
            bytes_left_ff <= bytes_left_in;
            send_win_ff   <= send_win_in;
            send_fill_ff  <= send_fill_in;
            send_flag_ff  <= send_flag_in;
         end
      end
      if (accept) begin
         pay_valid_ff <= pay_valid_in;
         pay_byte_ff  <= pay_byte_in;
         last_ff      <= last_in;
         herr_ff      <= herr_in;
         sok_ff       <= sok_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_valid = pay_valid_ff;
   assign rsp_payload_byte  = pay_byte_ff;
   assign rsp_frame_last    = last_ff;
   assign rsp_header_error  = herr_ff;
   assign rsp_send_ok_seen  = sok_ff;

`ifndef NO_ASSERTIONS
   // last beat of a frame is always a payload beat
   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!last_ff || pay_valid_ff))
      else $error("frame_last without payload_valid");

   // a header error wipes the send flag and passes no payload
   a_herr_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && herr_ff) |-> (!pay_valid_ff && !sok_ff))
      else $error("header_error with payload or send flag");

   // payload mode never runs with an empty count
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_PAYLOAD) |-> (bytes_left_ff != '0))
      else $error("payload mode with zero bytes left");

   // state moves only on an accepted beat
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!accept && !$past(reset)) |=> ($stable(mode_ff) && $stable(bytes_left_ff)))
      else $error("parser state changed without an accepted beat");
`endif

endmodule
`default_nettype wire
